// ----- sv/cbae_pkg.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier axis extent: shared package
// Coordinate and payload types and the derived widths of the datapath.
// ----------------------------------------------------------------------------
package cbae_pkg;

   localparam int COORD_BITS  = 24;
   localparam int T_FRAC_BITS = 16;

   // Power-basis coefficients: a = P3 - 3P2 + 3P1 - P0, b = P2 - 2P1 + P0, c = P1 - P0.
   localparam int A_BITS     = COORD_BITS + 3;
   localparam int B_BITS     = COORD_BITS + 2;
   localparam int C_BITS     = COORD_BITS + 1;
   localparam int MAG_A_BITS = COORD_BITS + 2;
   localparam int MAG_B_BITS = COORD_BITS + 1;
   localparam int MAG_C_BITS = COORD_BITS;
   localparam int PROD_BITS  = 2 * (COORD_BITS + 1);
   localparam int DISC_BITS  = PROD_BITS + 1;

   // Square root of disc * 2^(2T), one result bit per stage.
   localparam int SQRT_STEPS = (DISC_BITS + 2 * T_FRAC_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * SQRT_STEPS;
   localparam int REM_BITS   = SQRT_STEPS + 4;

   // Root numerator magnitude and divisor magnitude.
   localparam int NUM_BITS   = SQRT_STEPS + 1;
   localparam int DEN_BITS   = COORD_BITS + 3;
   localparam int DIV_STAGES = T_FRAC_BITS + 1;

   // Product of a coordinate difference and a root.
   localparam int LERP_BITS  = C_BITS + T_FRAC_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type start_coord;
      coord_type first_ctrl_coord;
      coord_type second_ctrl_coord;
      coord_type finish_coord;
   } req_type;

   typedef struct packed {
      coord_type extent_max;
      coord_type extent_min;
   } rsp_type;

endpackage

// ----- sv/cbae_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier axis extent: pipelined square root
// Floor square root of radicand * 2^(2*T_FRAC_BITS), one root bit per stage.
// ----------------------------------------------------------------------------
module cbae_sqrt_pipe (
   input  logic                              clock,
   input  logic [cbae_pkg::DISC_BITS-1:0]    radicand,
   output logic [cbae_pkg::SQRT_STEPS-1:0]   root
);

   logic [cbae_pkg::REM_BITS-1:0]   rem_ff  [cbae_pkg::SQRT_STEPS];
   logic [cbae_pkg::SQRT_STEPS-1:0] root_ff [cbae_pkg::SQRT_STEPS];
   logic [cbae_pkg::RAD_BITS-1:0]   rad_ff  [cbae_pkg::SQRT_STEPS];

   for (genvar k = 0; k < cbae_pkg::SQRT_STEPS; k++) begin : g_step
      logic [cbae_pkg::REM_BITS-1:0]   rem_prev, cur, trial, rem_in;
      logic [cbae_pkg::SQRT_STEPS-1:0] root_prev, root_in;
      logic [cbae_pkg::RAD_BITS-1:0]   rad_prev, rad_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = cbae_pkg::RAD_BITS'({radicand, {(2 * cbae_pkg::T_FRAC_BITS){1'b0}}});
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // Bring down the next two radicand bits and try the digit one.
      always_comb begin
         cur   = {rem_prev[cbae_pkg::REM_BITS-3:0], rad_prev[cbae_pkg::RAD_BITS-1 -: 2]};
         trial = cbae_pkg::REM_BITS'({root_prev, 2'b01});
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_prev[cbae_pkg::SQRT_STEPS-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_prev[cbae_pkg::SQRT_STEPS-2:0], 1'b0};
         end
         rad_in = rad_prev << 2;
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
      end
   end

   assign root = root_ff[cbae_pkg::SQRT_STEPS-1];

endmodule

// ----- sv/cbae_div_pipe.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier axis extent: pipelined root divider
// Restoring division of a positive numerator by a positive divisor, kept only
// when the quotient lies strictly between zero and one in Q0.T_FRAC_BITS.
// ----------------------------------------------------------------------------
module cbae_div_pipe (
   input  logic                               clock,
   input  logic [cbae_pkg::NUM_BITS-1:0]      num,
   input  logic [cbae_pkg::DEN_BITS-1:0]      den,
   input  logic                               enable,
   output logic [cbae_pkg::T_FRAC_BITS-1:0]   quot,
   output logic                               keep
);

   logic [cbae_pkg::NUM_BITS-1:0]    rem_ff [cbae_pkg::DIV_STAGES];
   logic [cbae_pkg::DEN_BITS-1:0]    den_ff [cbae_pkg::DIV_STAGES];
   logic [cbae_pkg::T_FRAC_BITS-1:0] q_ff   [cbae_pkg::DIV_STAGES];
   logic                             ok_ff  [cbae_pkg::DIV_STAGES];

   // First stage rejects any quotient of one or more.
   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      ok_ff[0]  <= enable &&
                   (num < cbae_pkg::NUM_BITS'({den, {cbae_pkg::T_FRAC_BITS{1'b0}}}));
   end

   for (genvar j = 1; j < cbae_pkg::DIV_STAGES; j++) begin : g_bit
      logic [cbae_pkg::NUM_BITS-1:0]    shifted, rem_in;
      logic [cbae_pkg::T_FRAC_BITS-1:0] q_in;

      always_comb begin
         shifted = cbae_pkg::NUM_BITS'(den_ff[j-1]) << (cbae_pkg::T_FRAC_BITS - j);
         q_in    = q_ff[j-1];
         if (rem_ff[j-1] >= shifted) begin
            rem_in                             = rem_ff[j-1] - shifted;
            q_in[cbae_pkg::T_FRAC_BITS - j]    = 1'b1;
         end else begin
            rem_in = rem_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= den_ff[j-1];
         q_ff[j]   <= q_in;
         ok_ff[j]  <= ok_ff[j-1];
      end
   end

   assign quot = q_ff[cbae_pkg::DIV_STAGES-1];
   assign keep = ok_ff[cbae_pkg::DIV_STAGES-1] && (q_ff[cbae_pkg::DIV_STAGES-1] != '0);

endmodule

// ----- sv/cubic_bezier_axis_extent.sv -----
// ----------------------------------------------------------------------------
// Cubic Bezier axis extent
// Largest and smallest coordinate reached by one axis of a cubic segment.
// ----------------------------------------------------------------------------
// Usage: present the four control coordinates of one axis on req_data and
// raise start. A transaction is taken at every rising edge with start high
// and busy low. busy is high only while reset is asserted, so outside reset
// a new transaction may be offered in every cycle.
// The block is a fixed pipeline: three stages form the coefficients, the
// products and the discriminant, the square-root unit adds one stage per root
// bit (SQRT_STEPS, 42 by default), one stage forms the root numerators, the
// two root dividers take T_FRAC_BITS + 1 stages (17), the de Casteljau
// evaluation six and the final maximum and minimum one. The result therefore
// appears on rsp_data with rsp_valid high for exactly one cycle, and the
// throughput is one transaction per cycle. Results leave in the order the
// transactions came in. The receiver cannot hold results off, so nothing in
// the pipeline ever stalls. A synchronous reset clears every valid bit;
// transactions in flight are dropped and no result is produced for them.
// ----------------------------------------------------------------------------
module cubic_bezier_axis_extent (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cbae_pkg::req_type req_data,
   output logic              rsp_valid,
   output cbae_pkg::rsp_type rsp_data
);

   // Data that travels beside the discriminant and the square root.
   typedef struct packed {
      logic                                 valid;
      cbae_pkg::coord_type [3:0]            pt;
      logic signed [cbae_pkg::A_BITS-1:0]   a;
      logic signed [cbae_pkg::B_BITS-1:0]   b;
      logic signed [cbae_pkg::C_BITS-1:0]   c;
      logic                                 a_zero;
      logic                                 b_zero;
      logic                                 ok;
   } side_type;

   // Data that travels beside the dividers and the evaluation.
   typedef struct packed {
      logic                                    valid;
      logic [1:0]                              keep;
      logic [1:0][cbae_pkg::T_FRAC_BITS-1:0]   t;
      cbae_pkg::coord_type                     pt0;
      cbae_pkg::coord_type                     pt3;
   } tail_type;

   typedef struct packed {
      logic                      valid;
      cbae_pkg::coord_type [3:0] pt;
   } pts_type;

   // (q - p) * t, with t taken as a non-negative fraction.
   function automatic logic signed [cbae_pkg::LERP_BITS-1:0] lerp_mul(
      cbae_pkg::coord_type p, cbae_pkg::coord_type q, logic [cbae_pkg::T_FRAC_BITS-1:0] t);
      logic signed [cbae_pkg::C_BITS-1:0]      diff;
      logic signed [cbae_pkg::T_FRAC_BITS:0]   ts;
      diff = cbae_pkg::C_BITS'(q) - cbae_pkg::C_BITS'(p);
      ts   = $signed({1'b0, t});
      return diff * ts;
   endfunction

   // p plus the product rounded half up; the result lies between p and q.
   function automatic cbae_pkg::coord_type lerp_add(
      cbae_pkg::coord_type p, logic signed [cbae_pkg::LERP_BITS-1:0] prod);
      logic signed [cbae_pkg::LERP_BITS-1:0] sum;
      sum = prod + (cbae_pkg::LERP_BITS'(1) <<< (cbae_pkg::T_FRAC_BITS - 1));
      return cbae_pkg::COORD_BITS'(cbae_pkg::C_BITS'(p) +
                                   cbae_pkg::C_BITS'(sum >>> cbae_pkg::T_FRAC_BITS));
   endfunction

   assign busy = reset;

   // ------------------------------------------------------------------
   // Stage 1: power-basis coefficients.
   // ------------------------------------------------------------------
   cbae_pkg::coord_type [3:0]          in_pt;
   logic signed [cbae_pkg::C_BITS-1:0] d0, d1, d2;
   side_type                           s1_side_in, s1_side_ff;

   always_comb begin
      in_pt[0] = req_data.start_coord;
      in_pt[1] = req_data.first_ctrl_coord;
      in_pt[2] = req_data.second_ctrl_coord;
      in_pt[3] = req_data.finish_coord;
      d0 = cbae_pkg::C_BITS'(in_pt[1]) - cbae_pkg::C_BITS'(in_pt[0]);
      d1 = cbae_pkg::C_BITS'(in_pt[2]) - cbae_pkg::C_BITS'(in_pt[1]);
      d2 = cbae_pkg::C_BITS'(in_pt[3]) - cbae_pkg::C_BITS'(in_pt[2]);
      s1_side_in        = '0;
      s1_side_in.valid  = start && !busy;
      s1_side_in.pt     = in_pt;
      s1_side_in.a      = cbae_pkg::A_BITS'(d0) - (cbae_pkg::A_BITS'(d1) <<< 1)
                          + cbae_pkg::A_BITS'(d2);
      s1_side_in.b      = cbae_pkg::B_BITS'(d1) - cbae_pkg::B_BITS'(d0);
      s1_side_in.c      = d0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
      end else begin
         s1_side_ff <= s1_side_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: magnitudes and the products b*b and a*c.
   // ------------------------------------------------------------------
   logic [cbae_pkg::MAG_A_BITS-1:0] a_mag;
   logic [cbae_pkg::MAG_B_BITS-1:0] b_mag;
   logic [cbae_pkg::MAG_C_BITS-1:0] c_mag;
   logic [cbae_pkg::PROD_BITS-1:0]  bb_in, ac_in, s2_bb_ff, s2_ac_ff;
   logic                            ac_neg_in, s2_ac_neg_ff;
   side_type                        s2_side_in, s2_side_ff;

   always_comb begin
      a_mag = s1_side_ff.a[cbae_pkg::A_BITS-1] ? cbae_pkg::MAG_A_BITS'(-s1_side_ff.a)
                                               : cbae_pkg::MAG_A_BITS'(s1_side_ff.a);
      b_mag = s1_side_ff.b[cbae_pkg::B_BITS-1] ? cbae_pkg::MAG_B_BITS'(-s1_side_ff.b)
                                               : cbae_pkg::MAG_B_BITS'(s1_side_ff.b);
      c_mag = s1_side_ff.c[cbae_pkg::C_BITS-1] ? cbae_pkg::MAG_C_BITS'(-s1_side_ff.c)
                                               : cbae_pkg::MAG_C_BITS'(s1_side_ff.c);
      bb_in = b_mag * b_mag;
      ac_in = a_mag * c_mag;
      ac_neg_in = (s1_side_ff.a[cbae_pkg::A_BITS-1] != s1_side_ff.c[cbae_pkg::C_BITS-1])
                  && (s1_side_ff.c != '0);
      s2_side_in        = s1_side_ff;
      s2_side_in.a_zero = (s1_side_ff.a == '0);
      s2_side_in.b_zero = (s1_side_ff.b == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff.valid <= 1'b0;
      end else begin
         s2_side_ff <= s2_side_in;
      end
      s2_bb_ff     <= bb_in;
      s2_ac_ff     <= ac_in;
      s2_ac_neg_ff <= ac_neg_in;
   end

   // ------------------------------------------------------------------
   // Stage 3: discriminant b*b - a*c; a negative one gives no root.
   // ------------------------------------------------------------------
   logic [cbae_pkg::DISC_BITS-1:0] disc_in, s3_disc_ff;
   side_type                       s3_side_in, s3_side_ff;

   always_comb begin
      s3_side_in    = s2_side_ff;
      s3_side_in.ok = s2_ac_neg_ff || (s2_bb_ff >= s2_ac_ff);
      if (s2_ac_neg_ff) begin
         disc_in = cbae_pkg::DISC_BITS'(s2_bb_ff) + cbae_pkg::DISC_BITS'(s2_ac_ff);
      end else begin
         disc_in = cbae_pkg::DISC_BITS'(s2_bb_ff) - cbae_pkg::DISC_BITS'(s2_ac_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.valid <= 1'b0;
      end else begin
         s3_side_ff <= s3_side_in;
      end
      s3_disc_ff <= disc_in;
   end

   // ------------------------------------------------------------------
   // Square root, with the side data delayed to match.
   // ------------------------------------------------------------------
   logic [cbae_pkg::SQRT_STEPS-1:0] sq_root;
   side_type                        sl_ff [cbae_pkg::SQRT_STEPS];

   cbae_sqrt_pipe u_sqrt (
      .clock    (clock),
      .radicand (s3_disc_ff),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbae_pkg::SQRT_STEPS; i++) begin
            sl_ff[i].valid <= 1'b0;
         end
      end else begin
         sl_ff[0] <= s3_side_ff;
         for (int i = 1; i < cbae_pkg::SQRT_STEPS; i++) begin
            sl_ff[i] <= sl_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: root numerators and divisor, signs normalised so that the
   // divisor is positive. With a zero leading term the linear root
   // -c / (2b) is the only candidate, and none remains if b is zero too.
   // ------------------------------------------------------------------
   side_type                              sq;
   logic signed [cbae_pkg::NUM_BITS:0]    base, sroot, n1, n2;
   logic signed [cbae_pkg::DEN_BITS:0]    den;
   logic                                  en1, en2;
   logic [cbae_pkg::NUM_BITS-1:0]         s4_n1_ff, s4_n2_ff;
   logic [cbae_pkg::DEN_BITS-1:0]         s4_den_ff;
   logic                                  s4_en1_ff, s4_en2_ff;
   pts_type                               s4_pts_ff;

   always_comb begin
      sq    = sl_ff[cbae_pkg::SQRT_STEPS-1];
      base  = -((cbae_pkg::NUM_BITS+1)'(sq.b) <<< cbae_pkg::T_FRAC_BITS);
      sroot = $signed((cbae_pkg::NUM_BITS+1)'(sq_root));
      if (sq.a_zero) begin
         n1  = -((cbae_pkg::NUM_BITS+1)'(sq.c) <<< cbae_pkg::T_FRAC_BITS);
         n2  = '0;
         den = (cbae_pkg::DEN_BITS+1)'(sq.b) <<< 1;
         en1 = !sq.b_zero;
         en2 = 1'b0;
      end else begin
         n1  = base + sroot;
         n2  = base - sroot;
         den = (cbae_pkg::DEN_BITS+1)'(sq.a);
         en1 = sq.ok;
         en2 = sq.ok;
      end
      if (den < 0) begin
         n1  = -n1;
         n2  = -n2;
         den = -den;
      end
      en1 = en1 && (n1 > 0);
      en2 = en2 && (n2 > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_pts_ff.valid <= 1'b0;
      end else begin
         s4_pts_ff.valid <= sq.valid;
         s4_pts_ff.pt    <= sq.pt;
      end
      s4_n1_ff  <= n1[cbae_pkg::NUM_BITS-1:0];
      s4_n2_ff  <= n2[cbae_pkg::NUM_BITS-1:0];
      s4_den_ff <= den[cbae_pkg::DEN_BITS-1:0];
      s4_en1_ff <= en1;
      s4_en2_ff <= en2;
   end

   // ------------------------------------------------------------------
   // Two root dividers, with the control points delayed to match.
   // ------------------------------------------------------------------
   logic [1:0][cbae_pkg::T_FRAC_BITS-1:0] tq;
   logic [1:0]                            tkeep;
   pts_type                               dl_ff [cbae_pkg::DIV_STAGES];

   cbae_div_pipe u_div_plus (
      .clock  (clock),
      .num    (s4_n1_ff),
      .den    (s4_den_ff),
      .enable (s4_en1_ff),
      .quot   (tq[0]),
      .keep   (tkeep[0])
   );

   cbae_div_pipe u_div_minus (
      .clock  (clock),
      .num    (s4_n2_ff),
      .den    (s4_den_ff),
      .enable (s4_en2_ff),
      .quot   (tq[1]),
      .keep   (tkeep[1])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbae_pkg::DIV_STAGES; i++) begin
            dl_ff[i].valid <= 1'b0;
         end
      end else begin
         dl_ff[0] <= s4_pts_ff;
         for (int i = 1; i < cbae_pkg::DIV_STAGES; i++) begin
            dl_ff[i] <= dl_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // De Casteljau evaluation at both roots: each level is one multiply
   // stage followed by one rounding add stage.
   // ------------------------------------------------------------------
   pts_type                                 dq;
   tail_type                                tail_in;
   tail_type                                e1_tl_ff, e2_tl_ff, e3_tl_ff, e4_tl_ff;
   tail_type                                e5_tl_ff, e6_tl_ff;
   logic signed [cbae_pkg::LERP_BITS-1:0]   e1_prod_ff [2][3];
   cbae_pkg::coord_type                     e1_p_ff    [2][3];
   cbae_pkg::coord_type                     e2_l_ff    [2][3];
   logic signed [cbae_pkg::LERP_BITS-1:0]   e3_prod_ff [2][2];
   cbae_pkg::coord_type                     e3_p_ff    [2][2];
   cbae_pkg::coord_type                     e4_l_ff    [2][2];
   logic signed [cbae_pkg::LERP_BITS-1:0]   e5_prod_ff [2];
   cbae_pkg::coord_type                     e5_p_ff    [2];
   cbae_pkg::coord_type                     e6_v_ff    [2];

   always_comb begin
      dq            = dl_ff[cbae_pkg::DIV_STAGES-1];
      tail_in.valid = dq.valid;
      tail_in.keep  = tkeep;
      tail_in.t     = tq;
      tail_in.pt0   = dq.pt[0];
      tail_in.pt3   = dq.pt[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_tl_ff.valid <= 1'b0;
         e2_tl_ff.valid <= 1'b0;
         e3_tl_ff.valid <= 1'b0;
         e4_tl_ff.valid <= 1'b0;
         e5_tl_ff.valid <= 1'b0;
         e6_tl_ff.valid <= 1'b0;
      end else begin
         e1_tl_ff <= tail_in;
         e2_tl_ff <= e1_tl_ff;
         e3_tl_ff <= e2_tl_ff;
         e4_tl_ff <= e3_tl_ff;
         e5_tl_ff <= e4_tl_ff;
         e6_tl_ff <= e5_tl_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 2; r++) begin
         for (int k = 0; k < 3; k++) begin
            e1_prod_ff[r][k] <= lerp_mul(dq.pt[k], dq.pt[k+1], tq[r]);
            e1_p_ff[r][k]    <= dq.pt[k];
            e2_l_ff[r][k]    <= lerp_add(e1_p_ff[r][k], e1_prod_ff[r][k]);
         end
         for (int k = 0; k < 2; k++) begin
            e3_prod_ff[r][k] <= lerp_mul(e2_l_ff[r][k], e2_l_ff[r][k+1], e2_tl_ff.t[r]);
            e3_p_ff[r][k]    <= e2_l_ff[r][k];
            e4_l_ff[r][k]    <= lerp_add(e3_p_ff[r][k], e3_prod_ff[r][k]);
         end
         e5_prod_ff[r] <= lerp_mul(e4_l_ff[r][0], e4_l_ff[r][1], e4_tl_ff.t[r]);
         e5_p_ff[r]    <= e4_l_ff[r][0];
         e6_v_ff[r]    <= lerp_add(e5_p_ff[r], e5_prod_ff[r]);
      end
   end

   // ------------------------------------------------------------------
   // Output stage: both ends always count, interior roots when kept.
   // ------------------------------------------------------------------
   cbae_pkg::coord_type hi, lo;
   cbae_pkg::rsp_type   rsp_data_in, rsp_data_ff;
   logic                rsp_valid_ff;

   always_comb begin
      hi = (e6_tl_ff.pt0 > e6_tl_ff.pt3) ? e6_tl_ff.pt0 : e6_tl_ff.pt3;
      lo = (e6_tl_ff.pt0 < e6_tl_ff.pt3) ? e6_tl_ff.pt0 : e6_tl_ff.pt3;
      for (int r = 0; r < 2; r++) begin
         if (e6_tl_ff.keep[r]) begin
            if (e6_v_ff[r] > hi) begin
               hi = e6_v_ff[r];
            end
            if (e6_v_ff[r] < lo) begin
               lo = e6_v_ff[r];
            end
         end
      end
      rsp_data_in.extent_max = hi;
      rsp_data_in.extent_min = lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= e6_tl_ff.valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.extent_max >= rsp_data.extent_min))
      else $error("extent maximum below extent minimum");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe straight after reset");

   a_max_covers_start: assert property (@(posedge clock) disable iff (reset)
      e6_tl_ff.valid |=> (rsp_data.extent_max >= $past(e6_tl_ff.pt0)))
      else $error("extent maximum below the start point");

   a_min_covers_finish: assert property (@(posedge clock) disable iff (reset)
      e6_tl_ff.valid |=> (rsp_data.extent_min <= $past(e6_tl_ff.pt3)))
      else $error("extent minimum above the end point");

endmodule
